// ----- hdl/rcpf_pkg.sv -----
// Shared types, constants and byte-forming functions of the control packet former.
`default_nettype none

package rcpf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgTxAddress = 3'd0;
  localparam logic [2:0] CfgHopA      = 3'd1;
  localparam logic [2:0] CfgHopB      = 3'd2;
  localparam logic [2:0] CfgHopC      = 3'd3;
  localparam logic [2:0] CfgHopD      = 3'd4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] TxAddressReset = 32'hA305_22C1;
  localparam logic [7:0]  HopAReset      = 8'd60;
  localparam logic [7:0]  HopBReset      = 8'd73;
  localparam logic [7:0]  HopCReset      = 8'd75;
  localparam logic [7:0]  HopDReset      = 8'd65;

  // Frame opcodes.
  localparam logic OpData = 1'b0;
  localparam logic OpBind = 1'b1;

  // Fixed frame bytes.
  localparam logic [7:0] HdrSync     = 8'h0F;
  localparam logic [7:0] HdrData     = 8'hA6;
  localparam logic [7:0] HdrBind     = 8'hA4;
  localparam logic [7:0] HdrDataTail = 8'hF7;
  localparam logic [7:0] FlagTakeoff = 8'h20;
  localparam logic [7:0] FlagEstop   = 8'h04;
  localparam logic [5:0] ThrottleTrim = 6'h1F;
  localparam logic [7:0] HopAvoid    = 8'h2D;

  // Bytes 0..13 are formed up front; byte 14 is the sum and byte 15 is zero.
  localparam int unsigned BodyBytes = 14;
  localparam logic [3:0] SumIdx  = 4'd14;
  localparam logic [3:0] LastIdx = 4'd15;

  typedef logic [BodyBytes-1:0][7:0] body_t;

  typedef struct packed {
    logic              opcode;
    logic signed [11:0] aileron;
    logic signed [11:0] elevator;
    logic signed [11:0] throttle;
    logic signed [11:0] rudder;
    logic signed [11:0] trim_aileron;
    logic signed [11:0] trim_elevator;
    logic signed [11:0] trim_rudder;
    logic              takeoff_land;
    logic              emergency_stop;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [31:0] tx_address;
    logic [7:0]  hop_a;
    logic [7:0]  hop_b;
    logic [7:0]  hop_c;
    logic [7:0]  hop_d;
  } cfg_t;

  // (v + 1023) / 2 rounded toward zero, clamped to 0..1023.
  function automatic logic [9:0] chan10(input logic signed [11:0] v);
    logic signed [12:0] s;
    logic [10:0]        x;
    s = {v[11], v} + 13'sd1023;
    x = s[11:1];
    if (s[12]) begin
      chan10 = 10'd0;
    end else if (x[10]) begin
      chan10 = 10'h3FF;
    end else begin
      chan10 = x[9:0];
    end
  endfunction

  // v / 32 rounded toward zero, plus 31, clamped to 0..63.
  function automatic logic [5:0] trim6(input logic signed [11:0] v);
    logic signed [11:0] a;
    logic signed [7:0]  t;
    a = v[11] ? (v + 12'sd31) : v;
    t = {a[11], a[11:5]} + 8'sd31;
    if (t[7]) begin
      trim6 = 6'd0;
    end else if (t[6]) begin
      trim6 = 6'h3F;
    end else begin
      trim6 = t[5:0];
    end
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    rev8 = r;
  endfunction

  // The avoided hop channel is moved up by one before the offset.
  function automatic logic [7:0] hop_adj(input logic [7:0] c);
    logic [7:0] m;
    m = (c == HopAvoid) ? (c + 8'd1) : c;
    hop_adj = m - 8'd2;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rcpf_front.sv -----
// Front end: holds the configuration and forms the frame body of each accepted item.
`default_nettype none

module rcpf_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rcpf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire rcpf_pkg::in_item_t            in_item_i,
  output rcpf_pkg::body_t                    body_o
);

  rcpf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_address <= rcpf_pkg::TxAddressReset;
      cfg_q.hop_a      <= rcpf_pkg::HopAReset;
      cfg_q.hop_b      <= rcpf_pkg::HopBReset;
      cfg_q.hop_c      <= rcpf_pkg::HopCReset;
      cfg_q.hop_d      <= rcpf_pkg::HopDReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcpf_pkg::CfgTxAddress: cfg_q.tx_address <= cfg_wdata_i;
        rcpf_pkg::CfgHopA:      cfg_q.hop_a <= cfg_wdata_i[7:0];
        rcpf_pkg::CfgHopB:      cfg_q.hop_b <= cfg_wdata_i[7:0];
        rcpf_pkg::CfgHopC:      cfg_q.hop_c <= cfg_wdata_i[7:0];
        rcpf_pkg::CfgHopD:      cfg_q.hop_d <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic [9:0] ch_ail, ch_ele, ch_thr, ch_rud;
  logic [5:0] tr_ail, tr_ele, tr_rud;

  always_comb begin
    ch_ail = rcpf_pkg::chan10(in_item_i.aileron);
    ch_ele = rcpf_pkg::chan10(in_item_i.elevator);
    ch_thr = rcpf_pkg::chan10(in_item_i.throttle);
    ch_rud = rcpf_pkg::chan10(in_item_i.rudder);
    tr_ail = rcpf_pkg::trim6(in_item_i.trim_aileron);
    tr_ele = rcpf_pkg::trim6(in_item_i.trim_elevator);
    tr_rud = rcpf_pkg::trim6(in_item_i.trim_rudder);

    body_o    = '0;
    body_o[0] = rcpf_pkg::HdrSync;
    if (in_item_i.opcode == rcpf_pkg::OpBind) begin
      body_o[1] = rcpf_pkg::HdrBind;
      body_o[2] = rcpf_pkg::rev8(cfg_q.tx_address[23:16]);
      body_o[3] = rcpf_pkg::rev8(cfg_q.tx_address[31:24]);
      body_o[4] = rcpf_pkg::rev8(cfg_q.tx_address[7:0]);
      body_o[5] = rcpf_pkg::rev8(cfg_q.tx_address[15:8]);
      body_o[6] = rcpf_pkg::hop_adj(cfg_q.hop_a);
      body_o[7] = rcpf_pkg::hop_adj(cfg_q.hop_b);
      body_o[8] = rcpf_pkg::hop_adj(cfg_q.hop_c);
      body_o[9] = rcpf_pkg::hop_adj(cfg_q.hop_d);
    end else begin
      body_o[1]  = rcpf_pkg::HdrData;
      body_o[2]  = rcpf_pkg::HdrDataTail;
      body_o[4]  = (in_item_i.takeoff_land ? rcpf_pkg::FlagTakeoff : 8'h00) |
                   (in_item_i.emergency_stop ? rcpf_pkg::FlagEstop : 8'h00);
      body_o[5]  = {tr_ail, ch_ail[9:8]};
      body_o[6]  = ch_ail[7:0];
      body_o[7]  = {tr_ele, ch_ele[9:8]};
      body_o[8]  = ch_ele[7:0];
      body_o[9]  = {rcpf_pkg::ThrottleTrim, ch_thr[9:8]};
      body_o[10] = ch_thr[7:0];
      body_o[11] = {tr_rud, ch_rud[9:8]};
      body_o[12] = ch_rud[7:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcpf_queue.sv -----
// Two-entry queue of formed frame bodies between the front and the back end.
`default_nettype none

module rcpf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rcpf_pkg::body_t push_data_i,
  input  wire logic            pop_i,
  output rcpf_pkg::body_t      head_o,
  output logic                 full_o,
  output logic                 empty_o
);

  rcpf_pkg::body_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    full_o   = count_q[1];
    empty_o  = (count_q == 2'd0);
    head_o   = mem_q[rd_ptr_q];
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcpf_back.sv -----
// Back end: sends the queued frame one byte per item, adding the checksum and the end mark.
`default_nettype none

module rcpf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rcpf_pkg::body_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rcpf_pkg::out_item_t  out_item_o
);

  logic                out_valid_q, out_valid_d;
  rcpf_pkg::out_item_t out_item_q, out_item_d;
  logic [3:0]          idx_q, idx_d;
  logic [7:0]          sum_q, sum_d;
  logic                advance;
  logic                send;
  logic [7:0]          cur_byte;

  always_comb begin
    advance = !out_valid_q || !out_stall_i;
    send    = advance && !empty_i;

    if (idx_q == rcpf_pkg::SumIdx) begin
      cur_byte = sum_q;
    end else if (idx_q == rcpf_pkg::LastIdx) begin
      cur_byte = 8'h00;
    end else begin
      cur_byte = head_i[idx_q];
    end

    pop_o       = send && (idx_q == rcpf_pkg::LastIdx);
    idx_d       = send ? (idx_q + 4'd1) : idx_q;
    // The running sum restarts on byte 0 of every frame.
    sum_d       = sum_q;
    if (send) begin
      sum_d = (idx_q == 4'd0) ? cur_byte : (sum_q + cur_byte);
    end
    out_valid_d = advance ? !empty_i : out_valid_q;
    out_item_d  = out_item_q;
    if (send) begin
      out_item_d.frame_byte = cur_byte;
      out_item_d.last_byte  = (idx_q == rcpf_pkg::LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
      sum_q       <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- hdl/rc_control_packet_former_unit.sv -----
// Top level of the radio control packet former.
`default_nettype none

// Each accepted item produces one 16-byte frame (data or bind) delivered as
// sixteen output items, one byte each, with last_byte set on the sixteenth.
// The front end forms bytes 0..13 in the cycle of acceptance and places them
// in a two-entry queue; the back end sends one byte per cycle while the output
// is not stalled and produces the checksum byte from a running sum. With no
// output stall the intake rate is set by the single byte-wide output.
// Up to two formed frames can wait in the queue while the output is stalled.
// Configuration writes take effect on frames accepted afterwards.
module rc_control_packet_former_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rcpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rcpf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rcpf_pkg::in_item_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rcpf_pkg::out_item_t                out_item_o
);

  rcpf_pkg::body_t body;
  rcpf_pkg::body_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  rcpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .body_o      (body)
  );

  rcpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (body),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  rcpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/rc_control_packet_former_unit_tb.sv -----
// Testbench for the radio control packet former: random and directed frames against a predictor.
`timescale 1ns / 100ps

module rc_control_packet_former_unit_tb;
  import rcpf_pkg::*;

  localparam int unsigned FrameBytes   = 16;
  localparam int unsigned PhaseRandom  = 78;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned SettleCycles = 4;

  // Holds the expected frame bytes and the register copy they are formed from.
  class frame_byte_board;
    out_item_t   pending_bytes[$];
    logic [31:0] tx_addr;
    logic [7:0]  hop[4];
    int unsigned errors;
    int unsigned checked;

    function new();
      tx_addr = TxAddressReset;
      hop[0]  = HopAReset;
      hop[1]  = HopBReset;
      hop[2]  = HopCReset;
      hop[3]  = HopDReset;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgTxAddress: tx_addr = val;
        CfgHopA: hop[0] = val[7:0];
        CfgHopB: hop[1] = val[7:0];
        CfgHopC: hop[2] = val[7:0];
        CfgHopD: hop[3] = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [9:0] stick_code(logic signed [11:0] v);
      int s;
      int x;
      s = v;
      x = (s + 1023) / 2;
      if (x < 0) x = 0;
      if (x > 1023) x = 1023;
      return x[9:0];
    endfunction

    function logic [5:0] trim_code(logic signed [11:0] v);
      int s;
      int x;
      s = v;
      x = s / 32 + 31;
      if (x < 0) x = 0;
      if (x > 63) x = 63;
      return x[5:0];
    endfunction

    function logic [7:0] mirror(logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7 - i] = b[i];
      return r;
    endfunction

    // Channel 45 is skipped by moving it up to 46 before the offset of two.
    function logic [7:0] hop_offset(logic [7:0] c);
      return (c == HopAvoid) ? c - 8'd1 : c - 8'd2;
    endfunction

    function void note_request(in_item_t it);
      logic [7:0] f[FrameBytes];
      logic [7:0] sum;
      logic [9:0] ch;
      out_item_t  o;
      for (int i = 0; i < FrameBytes; i++) f[i] = 8'h00;
      f[0] = HdrSync;
      if (it.opcode == OpBind) begin
        f[1] = HdrBind;
        f[2] = mirror(tx_addr[23:16]);
        f[3] = mirror(tx_addr[31:24]);
        f[4] = mirror(tx_addr[7:0]);
        f[5] = mirror(tx_addr[15:8]);
        for (int k = 0; k < 4; k++) f[6 + k] = hop_offset(hop[k]);
      end else begin
        f[1] = HdrData;
        f[2] = HdrDataTail;
        f[4] = (it.takeoff_land ? FlagTakeoff : 8'h00) | (it.emergency_stop ? FlagEstop : 8'h00);
        ch = stick_code(it.aileron);
        f[5] = {trim_code(it.trim_aileron), ch[9:8]};
        f[6] = ch[7:0];
        ch = stick_code(it.elevator);
        f[7] = {trim_code(it.trim_elevator), ch[9:8]};
        f[8] = ch[7:0];
        ch = stick_code(it.throttle);
        f[9] = {ThrottleTrim, ch[9:8]};
        f[10] = ch[7:0];
        ch = stick_code(it.rudder);
        f[11] = {trim_code(it.trim_rudder), ch[9:8]};
        f[12] = ch[7:0];
      end
      sum = 8'h00;
      for (int i = 0; i < BodyBytes; i++) sum = sum + f[i];
      f[SumIdx] = sum;
      for (int i = 0; i < FrameBytes; i++) begin
        o.frame_byte = f[i];
        o.last_byte  = (i == FrameBytes - 1);
        pending_bytes.push_back(o);
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected frame byte %02h last %0d", got.frame_byte, got.last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (want.frame_byte !== got.frame_byte || want.last_byte !== got.last_byte) begin
          errors++;
          if (errors <= ReportLimit)
            $display("frame %0d byte %0d: expected %02h last %0d, got %02h last %0d",
                     checked / FrameBytes, checked % FrameBytes, want.frame_byte,
                     want.last_byte, got.frame_byte, got.last_byte);
        end
        checked++;
      end
    endfunction

    function int unsigned waiting();
      return pending_bytes.size();
    endfunction

    function bit failed();
      return errors != 0 || pending_bytes.size() != 0;
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;

  frame_byte_board book = new();
  bit hold_off_request = 1'b0;

  rc_control_packet_former_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_byte(out_item_o);
  end

  // Receiver: segments of differing stall patterns, plus a long hold-off on request.
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request) begin
        hold_left = 150 + $urandom_range(0, 100);
        hold_off_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #800000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [11:0] random_stick();
    int v;
    int base;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 3072)) - 1536;
      2: begin
        case ($urandom_range(0, 3))
          0: base = 1024;
          1: base = 32;
          2: base = 1536;
          default: base = 2047;
        endcase
        v = ($urandom_range(0, 1) ? base : -base) + int'($urandom_range(0, 4)) - 2;
      end
      default: v = int'($urandom_range(0, 2048)) - 1024;
    endcase
    return v[11:0];
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    it.opcode         = ($urandom_range(0, 9) < 3) ? OpBind : OpData;
    it.aileron        = random_stick();
    it.elevator       = random_stick();
    it.throttle       = random_stick();
    it.rudder         = random_stick();
    it.trim_aileron   = random_stick();
    it.trim_elevator  = random_stick();
    it.trim_rudder    = random_stick();
    it.takeoff_land   = 1'($urandom_range(0, 1));
    it.emergency_stop = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t data_request(int a, int e, int t, int r, int ta, int te,
                                            int tr, bit tl, bit es);
    in_item_t it;
    it.opcode         = OpData;
    it.aileron        = a[11:0];
    it.elevator       = e[11:0];
    it.throttle       = t[11:0];
    it.rudder         = r[11:0];
    it.trim_aileron   = ta[11:0];
    it.trim_elevator  = te[11:0];
    it.trim_rudder    = tr[11:0];
    it.takeoff_land   = tl;
    it.emergency_stop = es;
    return it;
  endfunction

  function automatic in_item_t bind_request();
    in_item_t it;
    it = random_request();
    it.opcode = OpBind;
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_request(it);
  endtask

  // The payload is scrambled while valid is low; the block must not look at it.
  task automatic idle(input int unsigned cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    in_item_i  <= random_request();
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic settle();
    idle(1);
    while (book.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    book.write_reg(idx, val);
  endtask

  // Upper bits of the narrow registers carry noise that must be dropped.
  task automatic load_setting(input logic [31:0] tx, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [7:0] d);
    cfg_write(CfgTxAddress, tx);
    cfg_write(CfgHopA, {24'($urandom), a});
    cfg_write(CfgHopB, {24'($urandom), b});
    cfg_write(CfgHopC, {24'($urandom), c});
    cfg_write(CfgHopD, {24'($urandom), d});
  endtask

  task automatic random_run(input int unsigned count);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    hold_off_request = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        if (gap != 0) idle(gap);
        burst_left = $urandom_range(1, 30);
      end
      offer(random_request());
      burst_left--;
    end
  endtask

  function automatic logic [7:0] random_hop();
    return ($urandom_range(0, 3) == 0) ? HopAvoid : 8'($urandom);
  endfunction

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: clamp edges of sticks and trims, flag combinations, two bind frames.
    offer(data_request(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    offer(data_request(2047, 2047, 2047, 2047, 2047, 2047, 2047, 1'b1, 1'b1));
    offer(data_request(-2048, -2048, -2048, -2048, -2048, -2048, -2048, 1'b1, 1'b0));
    offer(data_request(1024, -1024, 1536, -1536, 1024, -1024, 1536, 1'b0, 1'b1));
    offer(data_request(1023, -1023, 1025, -1022, -32, -31, 31, 1'b0, 1'b0));
    offer(data_request(-1, 1, -2, 2, -33, 32, 33, 1'b1, 1'b0));
    offer(data_request(-1025, 1026, -1024, 1022, 1023, -992, -993, 1'b0, 1'b0));
    offer(data_request(1536, -1536, 0, 1, -1536, 1536, -1, 1'b1, 1'b1));
    offer(bind_request());
    offer(data_request(-1536, 1536, -1023, 1023, -1024, 1024, 0, 1'b0, 1'b1));
    offer(bind_request());
    random_run(PhaseRandom);
    settle();

    // All-zero setting; writes to unused indexes must change nothing.
    load_setting(32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0);
    for (int k = int'(CfgHopD) + 1; k < (1 << CfgIdxW); k++)
      cfg_write(k[CfgIdxW-1:0], $urandom);
    offer(bind_request());
    random_run(PhaseRandom);
    settle();

    load_setting(32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    offer(bind_request());
    random_run(PhaseRandom);
    settle();

    // Every hop channel on the avoided value.
    load_setting($urandom, HopAvoid, HopAvoid, HopAvoid, HopAvoid);
    offer(bind_request());
    random_run(PhaseRandom);
    settle();

    load_setting($urandom, HopAvoid + 8'd1, HopAvoid - 8'd1, 8'd1, 8'd2);
    offer(bind_request());
    random_run(PhaseRandom);
    settle();

    load_setting($urandom, random_hop(), random_hop(), random_hop(), random_hop());
    offer(bind_request());
    random_run(PhaseRandom);

    idle(1);
    while (book.waiting() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (book.failed()) begin
      $display("Regression FAIL");
    end else begin
      $display("Regression PASS");
    end
    $finish;
  end

endmodule
